FILE: hdl/u16u8_pkg.sv
// Shared types and constants for the UTF-16 to UTF-8 encoder.
package u16u8_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int MAX_BYTES   = 6;
    localparam int COUNT_W     = 3;

    localparam logic [7:0] LEAD4_BYTE = 8'hF0;
    localparam logic [7:0] LEAD3_BYTE = 8'hE0;
    localparam logic [7:0] LEAD2_BYTE = 8'hC0;
    localparam logic [7:0] CONT_BYTE  = 8'h80;
    localparam logic [7:0] SURR_LEAD  = 8'hED;
    localparam logic [7:0] SURR_CONT  = 8'hA0;

    localparam logic [15:0] MASK_ONE   = 16'hFF80;
    localparam logic [15:0] MASK_TWO   = 16'hF800;
    localparam logic [15:0] MASK_SURR  = 16'hFC00;
    localparam logic [15:0] HIGH_SURR  = 16'hD800;
    localparam logic [15:0] LOW_SURR   = 16'hDC00;
    localparam logic [20:0] PLANE_BASE = 21'h10000;

    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [COUNT_W-1:0]        count;
        logic                      done;
    } desc_t;

endpackage

FILE: hdl/u16u8_front.sv
// Front end: accepts code units, tracks the held high surrogate, builds byte groups.
module u16u8_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [15:0]         s_code_unit,
    input  logic                s_end_of_string,
    output logic                push_valid,
    input  logic                push_ready,
    output u16u8_pkg::desc_t    push_data
);
    import u16u8_pkg::*;

    logic [9:0]  held_bits_reg, held_bits_next;
    logic        held_valid_reg, held_valid_next;
    logic        is_low, is_high, pair, flush, store;
    logic        accept;
    logic [20:0] cp;
    logic [2:0][7:0] unit_bytes;
    logic [2:0][7:0] flush_bytes;
    logic [COUNT_W-1:0] unit_count;
    desc_t       desc;

    assign s_ready = push_ready;
    assign accept  = s_valid && push_ready;

    always_comb begin
        is_low  = (s_code_unit & MASK_SURR) == LOW_SURR;
        is_high = (s_code_unit & MASK_SURR) == HIGH_SURR;
        pair    = held_valid_reg && is_low;
        flush   = held_valid_reg && !is_low;
        store   = is_high && !s_end_of_string;
        cp      = PLANE_BASE + {1'b0, held_bits_reg, s_code_unit[9:0]};

        flush_bytes[0] = SURR_LEAD;
        flush_bytes[1] = SURR_CONT | {4'h0, held_bits_reg[9:6]};
        flush_bytes[2] = CONT_BYTE | {2'b00, held_bits_reg[5:0]};

        unit_bytes = '0;
        if ((s_code_unit & MASK_ONE) == 16'h0000) begin
            unit_bytes[0] = s_code_unit[7:0];
            unit_count    = COUNT_W'(1);
        end else if ((s_code_unit & MASK_TWO) == 16'h0000) begin
            unit_bytes[0] = LEAD2_BYTE | {3'b000, s_code_unit[10:6]};
            unit_bytes[1] = CONT_BYTE | {2'b00, s_code_unit[5:0]};
            unit_count    = COUNT_W'(2);
        end else if (store) begin
            unit_count    = COUNT_W'(0);
        end else begin
            unit_bytes[0] = LEAD3_BYTE | {4'h0, s_code_unit[15:12]};
            unit_bytes[1] = CONT_BYTE | {2'b00, s_code_unit[11:6]};
            unit_bytes[2] = CONT_BYTE | {2'b00, s_code_unit[5:0]};
            unit_count    = COUNT_W'(3);
        end

        desc       = '0;
        desc.done  = s_end_of_string;
        if (pair) begin
            desc.bytes[0] = LEAD4_BYTE | {5'b00000, cp[20:18]};
            desc.bytes[1] = CONT_BYTE | {2'b00, cp[17:12]};
            desc.bytes[2] = CONT_BYTE | {2'b00, cp[11:6]};
            desc.bytes[3] = CONT_BYTE | {2'b00, cp[5:0]};
            desc.count    = COUNT_W'(4);
        end else if (flush) begin
            desc.bytes[2:0] = flush_bytes;
            desc.bytes[5:3] = unit_bytes;
            desc.count      = unit_count + COUNT_W'(3);
        end else begin
            desc.bytes[2:0] = unit_bytes;
            desc.count      = unit_count;
        end

        held_valid_next = held_valid_reg;
        held_bits_next  = held_bits_reg;
        if (accept) begin
            if (!pair && store) begin
                held_valid_next = 1'b1;
                held_bits_next  = s_code_unit[9:0];
            end else begin
                held_valid_next = 1'b0;
                held_bits_next  = '0;
            end
        end
    end

    assign push_valid = s_valid && (desc.count != '0);
    assign push_data  = desc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_valid_reg <= 1'b0;
            held_bits_reg  <= '0;
        end else begin
            held_valid_reg <= held_valid_next;
            held_bits_reg  <= held_bits_next;
        end
    end

endmodule

FILE: hdl/u16u8_queue.sv
// Short queue of byte groups between front end and serializer.
module u16u8_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_valid,
    output logic                push_ready,
    input  u16u8_pkg::desc_t    push_data,
    output logic                pop_valid,
    input  logic                pop_ready,
    output u16u8_pkg::desc_t    pop_data
);
    import u16u8_pkg::*;

    desc_t                mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]    fill_reg, fill_next;
    logic                 do_push, do_pop;

    assign push_ready = fill_reg != (QUEUE_AW+1)'(QUEUE_DEPTH);
    assign pop_valid  = fill_reg != '0;
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + QUEUE_AW'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = fill_reg + (QUEUE_AW+1)'(1);
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - (QUEUE_AW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

FILE: hdl/u16u8_back.sv
// Serializer: sends one byte of the current group per cycle while m_ready is high.
module u16u8_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  u16u8_pkg::desc_t    pop_data,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_out_byte,
    output logic                m_string_done
);
    import u16u8_pkg::*;

    desc_t              cur_reg;
    logic               cur_valid_reg;
    logic [COUNT_W-1:0] idx_reg;
    logic               last;

    assign last          = idx_reg == (cur_reg.count - COUNT_W'(1));
    assign pop_ready     = !cur_valid_reg || (m_ready && last);
    assign m_valid       = cur_valid_reg;
    assign m_out_byte    = cur_reg.bytes[idx_reg];
    assign m_string_done = cur_reg.done && last;

    always_ff @(posedge aclk) begin
        if (pop_ready && pop_valid) begin
            cur_reg <= pop_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else if (pop_ready) begin
            cur_valid_reg <= pop_valid;
            idx_reg       <= '0;
        end else if (m_ready) begin
            idx_reg       <= idx_reg + COUNT_W'(1);
        end
    end

endmodule

FILE: hdl/utf16_to_utf8_encoder.sv
// Top level of the UTF-16 to UTF-8 encoder.
//
//   channel  direction  payload                          handshake
//   s_       in         code_unit[16], end_of_string[1]  s_valid / s_ready
//   m_       out        out_byte[8], string_done[1]      m_valid / m_ready
//
// One output byte per cycle while m_ready is high; a code unit yields 0 to 6
// bytes, which the serializer sends in turn. The front end takes one code unit
// per cycle while the four-entry group queue has room.
// Synchronous active-low reset empties the queue and drops any held surrogate.
// Either side may stall at any time; the queue decouples them.
module utf16_to_utf8_encoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_code_unit,
    input  logic        s_end_of_string,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_string_done
);
    import u16u8_pkg::*;

    logic  push_valid, push_ready, pop_valid, pop_ready;
    desc_t push_data, pop_data;

    u16u8_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_code_unit     (s_code_unit),
        .s_end_of_string (s_end_of_string),
        .push_valid      (push_valid),
        .push_ready      (push_ready),
        .push_data       (push_data)
    );

    u16u8_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    u16u8_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_data      (pop_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_string_done (m_string_done)
    );

endmodule

FILE: dv/utf16_to_utf8_encoder_tb.sv
// Self-checking testbench for the UTF-16 to UTF-8 encoder with a predicting scoreboard.
`timescale 1ns / 100ps

module utf16_to_utf8_encoder_tb;
    import u16u8_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int LONG_HOLD     = 80;
    localparam int DRAIN_CYCLES  = 20;
    localparam int UNITS_PER_PHASE = 34;

    typedef struct {
        logic [15:0] unit;
        logic        eos;
    } unit_item_t;

    typedef struct {
        logic [7:0] data;
        logic       done;
    } utf8_byte_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [15:0] s_code_unit = 16'h0000;
    logic        s_end_of_string = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_out_byte;
    logic        m_string_done;

    unit_item_t  pending_units[$];
    utf8_byte_t  utf8_expected[$];

    logic [9:0]  held_bits = 10'h000;
    logic        surr_held = 1'b0;

    logic        in_taken = 1'b0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    logic        stall_go = 1'b0;
    logic        stall_done = 1'b0;
    int          stall_count = 0;
    int          idle_cycles = 0;
    int          error_count = 0;
    int          units_queued = 0;

    utf16_to_utf8_encoder DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_code_unit     (s_code_unit),
        .s_end_of_string (s_end_of_string),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_string_done   (m_string_done)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic logic [23:0] three_byte_seq(input logic [15:0] u);
        return {LEAD3_BYTE | {4'h0, u[15:12]}, CONT_BYTE | {2'b00, u[11:6]},
                CONT_BYTE | {2'b00, u[5:0]}};
    endfunction

    function automatic void encode_code_unit(input logic [15:0] u, input logic eos);
        logic [7:0]  seq[$];
        logic [20:0] cp;
        logic [23:0] tri_seq;
        logic        paired;
        utf8_byte_t  b;
        paired = 1'b0;
        if (surr_held) begin
            surr_held = 1'b0;
            if ((u & MASK_SURR) == LOW_SURR) begin
                paired = 1'b1;
                cp = PLANE_BASE + (21'(held_bits) << 10) + 21'(u[9:0]);
                seq = {seq, LEAD4_BYTE | {5'b00000, cp[20:18]}};
                seq = {seq, CONT_BYTE | {2'b00, cp[17:12]}};
                seq = {seq, CONT_BYTE | {2'b00, cp[11:6]}};
                seq = {seq, CONT_BYTE | {2'b00, cp[5:0]}};
            end else begin
                tri_seq = three_byte_seq(HIGH_SURR | {6'b000000, held_bits});
                seq = {seq, tri_seq[23:16]};
                seq = {seq, tri_seq[15:8]};
                seq = {seq, tri_seq[7:0]};
            end
            held_bits = 10'h000;
        end
        if (!paired) begin
            if ((u & MASK_ONE) == 16'h0000) begin
                seq = {seq, u[7:0]};
            end else if ((u & MASK_TWO) == 16'h0000) begin
                seq = {seq, LEAD2_BYTE | {3'b000, u[10:6]}};
                seq = {seq, CONT_BYTE | {2'b00, u[5:0]}};
            end else if ((u & MASK_SURR) == HIGH_SURR && !eos) begin
                held_bits = u[9:0];
                surr_held = 1'b1;
            end else begin
                tri_seq = three_byte_seq(u);
                seq = {seq, tri_seq[23:16]};
                seq = {seq, tri_seq[15:8]};
                seq = {seq, tri_seq[7:0]};
            end
        end
        foreach (seq[i]) begin
            b.data = seq[i];
            b.done = eos && (i == seq.size() - 1);
            utf8_expected = {utf8_expected, b};
        end
    endfunction

    function automatic void queue_unit(input logic [15:0] u, input logic eos);
        unit_item_t it;
        it.unit = u;
        it.eos  = eos;
        pending_units = {pending_units, it};
        units_queued++;
    endfunction

    function automatic logic [15:0] rand_high_surr();
        return HIGH_SURR | 16'($urandom_range(1023));
    endfunction

    function automatic logic [15:0] rand_low_surr();
        return LOW_SURR | 16'($urandom_range(1023));
    endfunction

    function automatic logic [15:0] rand_bmp3();
        if ($urandom_range(1) == 0) begin
            return 16'($urandom_range(16'hD7FF, 16'h0800));
        end
        return 16'($urandom_range(16'hFFFF, 16'hE000));
    endfunction

    // Build one string: mostly valid text, some lone surrogates, some raw noise.
    function automatic void queue_string(input int n_chars);
        int  r;
        logic noise;
        noise = ($urandom_range(9) == 0);
        for (int i = 0; i < n_chars; i++) begin
            r = $urandom_range(99);
            if (noise) begin
                queue_unit(16'($urandom_range(16'hFFFF)), 1'b0);
            end else if (r < 25) begin
                queue_unit(16'($urandom_range(16'h007F)), 1'b0);
            end else if (r < 45) begin
                queue_unit(16'($urandom_range(16'h07FF, 16'h0080)), 1'b0);
            end else if (r < 65) begin
                queue_unit(rand_bmp3(), 1'b0);
            end else if (r < 87) begin
                queue_unit(rand_high_surr(), 1'b0);
                queue_unit(rand_low_surr(), 1'b0);
            end else if (r < 94) begin
                queue_unit(rand_high_surr(), 1'b0);
            end else begin
                queue_unit(rand_low_surr(), 1'b0);
            end
        end
        pending_units[$].eos = 1'b1;
    endfunction

    function automatic void queue_directed();
        queue_unit(16'h0000, 1'b0);
        queue_unit(16'h007F, 1'b0);
        queue_unit(16'h0080, 1'b0);
        queue_unit(16'h07FF, 1'b0);
        queue_unit(16'h0800, 1'b0);
        queue_unit(16'hD7FF, 1'b0);
        queue_unit(16'hE000, 1'b0);
        queue_unit(16'hFFFF, 1'b1);
        queue_unit(16'hD800, 1'b0);
        queue_unit(16'hDC00, 1'b0);
        queue_unit(16'hDBFF, 1'b0);
        queue_unit(16'hDFFF, 1'b1);
        queue_unit(16'hDAAA, 1'b0);
        queue_unit(16'h0041, 1'b0);
        queue_unit(16'hD955, 1'b0);
        queue_unit(16'hDB00, 1'b0);
        queue_unit(16'hDD55, 1'b0);
        queue_unit(16'hDC00, 1'b0);
        queue_unit(16'hDBFF, 1'b1);
        queue_unit(16'hD801, 1'b0);
        queue_unit(16'h0000, 1'b1);
        queue_unit(16'hD8FF, 1'b0);
        queue_unit(16'hFFFF, 1'b1);
        queue_unit(16'h0000, 1'b1);
    endfunction

    // Sender: advance to the next item once the current one is taken.
    always @(negedge aclk) begin
        unit_item_t nxt;
        if (aresetn && (!s_valid || in_taken)) begin
            if (pending_units.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = pending_units.pop_front();
                s_valid         <= 1'b1;
                s_code_unit     <= nxt.unit;
                s_end_of_string <= nxt.eos;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure plus one long hold-off.
    always @(negedge aclk) begin
        if (stall_go && !stall_done) begin
            m_ready <= 1'b0;
            stall_count = stall_count + 1;
            if (stall_count >= LONG_HOLD) begin
                stall_done = 1'b1;
            end
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        utf8_byte_t exp_byte;
        if (!aresetn) begin
            in_taken    <= 1'b0;
            surr_held   = 1'b0;
            held_bits   = 10'h000;
            idle_cycles = 0;
        end else begin
            in_taken <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                encode_code_unit(s_code_unit, s_end_of_string);
            end
            if (m_valid && m_ready) begin
                if (utf8_expected.size() == 0) begin
                    report_mismatch($sformatf("unexpected byte %02h done %0b",
                                              m_out_byte, m_string_done));
                end else begin
                    exp_byte = utf8_expected.pop_front();
                    if (m_out_byte !== exp_byte.data) begin
                        report_mismatch($sformatf("out_byte got %02h exp %02h",
                                                  m_out_byte, exp_byte.data));
                    end
                    if (m_string_done !== exp_byte.done) begin
                        report_mismatch($sformatf("string_done got %0b exp %0b (byte %02h)",
                                                  m_string_done, exp_byte.done,
                                                  exp_byte.data));
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles = idle_cycles + 1;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("utf16_to_utf8_encoder_tb: errors");
                $finish;
            end
        end
    end

    initial begin
        int send_pct[3];
        int recv_pct[3];
        send_pct = '{21, 56, 0};
        recv_pct = '{56, 21, 0};
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = send_pct[ph];
            recv_idle_pct = recv_pct[ph];
            units_queued  = 0;
            if (ph == 0) begin
                queue_directed();
                units_queued = 0;
            end
            if (ph == 2) begin
                stall_go = 1'b1;
            end
            while (units_queued < UNITS_PER_PHASE) begin
                queue_string($urandom_range(6, 1));
            end
            while (pending_units.size() != 0) @(posedge aclk);
        end
        while (pending_units.size() != 0 || s_valid) @(posedge aclk);
        while (utf8_expected.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (utf8_expected.size() != 0) begin
            report_mismatch($sformatf("%0d expected bytes never arrived",
                                      utf8_expected.size()));
        end
        if (error_count == 0) begin
            $display("utf16_to_utf8_encoder_tb: clean");
        end else begin
            $display("utf16_to_utf8_encoder_tb: errors");
        end
        $finish;
    end

endmodule
